### src/mcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcg_pkg: shared types, constants and calendar helpers
// Field widths, datapath command codes and month tables for the grid generator.
// ----------------------------------------------------------------------------
package mcg_pkg;

	localparam int YearW  = 14;
	localparam int MonthW = 4;
	localparam int DayW   = 5;
	localparam int PosW   = 3;
	localparam int ProdW  = 29;

	localparam logic [YearW-1:0]  YEAR_MIN  = 14'd1;
	localparam logic [YearW-1:0]  YEAR_MAX  = 14'd9999;
	localparam logic [MonthW-1:0] MONTH_JAN = 4'd1;
	localparam logic [MonthW-1:0] MONTH_FEB = 4'd2;
	localparam logic [MonthW-1:0] MONTH_DEC = 4'd12;

	// floor(x / 100) = (x * 5243) >> 19 for x below 10000
	localparam logic [12:0] DIV100_RECIP = 13'd5243;
	localparam int          DIV100_SHIFT = 19;
	localparam int          Q100W        = 7;
	// floor(x / 7) = (x * 37450) >> 18 for x below 16384
	localparam logic [15:0] DIV7_RECIP   = 16'd37450;
	localparam int          DIV7_SHIFT   = 18;
	localparam int          Q7W          = 11;

	localparam logic [PosW-1:0] LAST_ROW = 3'd5;
	localparam logic [PosW-1:0] LAST_COL = 3'd6;

	// Datapath commands, one per controller step
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV,
		OP_SUM,
		OP_DOY,
		OP_MOD,
		OP_WDAY,
		OP_START,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		logic last;
	} dp_status_t;

	function automatic logic [DayW-1:0] days_in(input logic [MonthW-1:0] m, input logic leap);
		logic [DayW-1:0] d;
		case (m)
			4'd2:                     d = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:  d = 5'd30;
			default:                  d = 5'd31;
		endcase
		return d;
	endfunction

	// Days of a common year before the first of month m
	function automatic logic [8:0] days_before(input logic [MonthW-1:0] m);
		logic [8:0] d;
		case (m)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

### src/mcg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcg_ctrl: request sequencer
// Steps the datapath through the weekday setup and then one cell per cycle.
// ----------------------------------------------------------------------------
module mcg_ctrl
	import mcg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t status,
	output dp_op_t     op,
	output logic       busy
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SUM,
		ST_DOY,
		ST_MOD,
		ST_WDAY,
		ST_START,
		ST_RUN
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:  if (start) state_q <= ST_DIV;
				ST_DIV:   state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_DOY;
				ST_DOY:   state_q <= ST_MOD;
				ST_MOD:   state_q <= ST_WDAY;
				ST_WDAY:  state_q <= ST_START;
				ST_START: state_q <= ST_RUN;
				ST_RUN:   if (status.last) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		case (state_q)
			ST_IDLE:  op = start ? OP_LOAD : OP_NONE;
			ST_DIV:   op = OP_DIV;
			ST_SUM:   op = OP_SUM;
			ST_DOY:   op = OP_DOY;
			ST_MOD:   op = OP_MOD;
			ST_WDAY:  op = OP_WDAY;
			ST_START: op = OP_START;
			ST_RUN:   op = OP_EMIT;
			default:  op = OP_NONE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

### src/mcg_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcg_dpath: calendar datapath
// Weekday arithmetic with one shared multiplier, date counter and cell flags.
// ----------------------------------------------------------------------------
module mcg_dpath
	import mcg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  dp_op_t            op,
	output dp_status_t        status,
	input  logic [YearW-1:0]  sel_year,
	input  logic [MonthW-1:0] sel_month,
	input  logic [DayW-1:0]   sel_day,
	input  logic [YearW-1:0]  today_year,
	input  logic [MonthW-1:0] today_month,
	input  logic [DayW-1:0]   today_day,
	output logic              cell_valid,
	output logic [YearW-1:0]  cell_year,
	output logic [MonthW-1:0] cell_month,
	output logic [DayW-1:0]   cell_day,
	output logic [PosW-1:0]   cell_row,
	output logic [PosW-1:0]   cell_column,
	output logic              is_today,
	output logic              in_sel_month,
	output logic              is_selected,
	output logic              last_cell
);

	logic [YearW-1:0]  sy_q;
	logic [MonthW-1:0] sm_q;
	logic [DayW-1:0]   sd_q;
	logic [ProdW-1:0]  prod_q;
	logic              leap_q;
	logic [YearW-1:0]  base_q;
	logic [YearW-1:0]  sum_q;
	logic [PosW-1:0]   w_q;
	logic [YearW-1:0]  year_q;
	logic [MonthW-1:0] month_q;
	logic [DayW-1:0]   day_q;
	logic [PosW-1:0]   row_q;
	logic [PosW-1:0]   col_q;
	logic              valid_q;
	logic [YearW-1:0]  out_year_q;
	logic [MonthW-1:0] out_month_q;
	logic [DayW-1:0]   out_day_q;
	logic [PosW-1:0]   out_row_q;
	logic [PosW-1:0]   out_col_q;
	logic              out_today_q;
	logic              out_insel_q;
	logic              out_sel_q;
	logic              out_last_q;

	logic [YearW-1:0]  y1;
	logic [Q100W-1:0]  q100;
	logic [YearW-1:0]  hund;
	logic [YearW-1:0]  r100;
	logic              leap;
	logic [Q7W-1:0]    q7;
	logic [YearW-1:0]  seven;
	logic [YearW-1:0]  r7;
	logic [MonthW-1:0] prev_month;
	logic [YearW-1:0]  prev_year;
	logic [DayW-1:0]   dim;
	logic              at_last;
	logic              insel;

	assign y1    = sy_q - YEAR_MIN;
	assign q100  = prod_q[DIV100_SHIFT +: Q100W];
	assign hund  = {{(YearW-Q100W){1'b0}}, q100} * 14'd100;
	assign r100  = y1 - hund;
	// sy divisible by 100 exactly when (sy-1) mod 100 is 99
	assign leap  = (sy_q[1:0] == 2'b00) && ((r100 != 14'd99) || (q100[1:0] == 2'b11));
	assign q7    = prod_q[DIV7_SHIFT +: Q7W];
	assign seven = {q7, 3'b000} - {3'b000, q7};
	assign r7    = sum_q - seven;

	assign prev_month = (sm_q == MONTH_JAN) ? MONTH_DEC : (sm_q - 4'd1);
	assign prev_year  = (sm_q == MONTH_JAN) ? (sy_q - 14'd1) : sy_q;
	assign dim        = days_in(month_q, leap_q);
	assign at_last    = (row_q == LAST_ROW) && (col_q == LAST_COL);
	assign insel      = (month_q == sm_q);

	assign status.last = at_last;

	// Weekday setup and date counter
	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				if (sel_year == 14'd0)
					sy_q <= YEAR_MIN;
				else if (sel_year > YEAR_MAX)
					sy_q <= YEAR_MAX;
				else
					sy_q <= sel_year;
				if (sel_month == 4'd0)
					sm_q <= MONTH_JAN;
				else if (sel_month > MONTH_DEC)
					sm_q <= MONTH_DEC;
				else
					sm_q <= sel_month;
				sd_q <= sel_day;
			end
			OP_DIV: begin
				prod_q <= {{(ProdW-YearW){1'b0}}, y1} * {{(ProdW-13){1'b0}}, DIV100_RECIP};
			end
			OP_SUM: begin
				leap_q <= leap;
				base_q <= y1 + {2'b00, y1[YearW-1:2]} - {{(YearW-Q100W){1'b0}}, q100}
					+ {{(YearW-Q100W+2){1'b0}}, q100[Q100W-1:2]};
			end
			OP_DOY: begin
				sum_q <= base_q + {5'd0, days_before(sm_q)} + 14'd1
					+ {13'd0, (leap_q && (sm_q > MONTH_FEB))};
			end
			OP_MOD: begin
				prod_q <= {{(ProdW-YearW){1'b0}}, sum_q} * {{(ProdW-16){1'b0}}, DIV7_RECIP};
			end
			OP_WDAY: begin
				// Sunday counts as seven: a whole week of the prior month leads
				w_q <= (r7[2:0] == 3'd0) ? 3'd7 : r7[2:0];
			end
			OP_START: begin
				year_q  <= prev_year;
				month_q <= prev_month;
				day_q   <= days_in(prev_month, leap_q) - {2'b00, w_q} + 5'd1;
				row_q   <= '0;
				col_q   <= '0;
			end
			OP_EMIT: begin
				out_year_q  <= year_q;
				out_month_q <= month_q;
				out_day_q   <= day_q;
				out_row_q   <= row_q;
				out_col_q   <= col_q;
				out_today_q <= (year_q == today_year) && (month_q == today_month)
					&& (day_q == today_day);
				out_insel_q <= insel;
				out_sel_q   <= insel && (year_q == sy_q) && (day_q == sd_q);
				out_last_q  <= at_last;
				if (col_q == LAST_COL) begin
					col_q <= '0;
					row_q <= row_q + 3'd1;
				end else begin
					col_q <= col_q + 3'd1;
				end
				if (day_q == dim) begin
					day_q <= 5'd1;
					if (month_q == MONTH_DEC) begin
						month_q <= MONTH_JAN;
						year_q  <= year_q + 14'd1;
					end else begin
						month_q <= month_q + 4'd1;
					end
				end else begin
					day_q <= day_q + 5'd1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= (op == OP_EMIT);
		end
	end

	assign cell_valid   = valid_q;
	assign cell_year    = out_year_q;
	assign cell_month   = out_month_q;
	assign cell_day     = out_day_q;
	assign cell_row     = out_row_q;
	assign cell_column  = out_col_q;
	assign is_today     = out_today_q;
	assign in_sel_month = out_insel_q;
	assign is_selected  = out_sel_q;
	assign last_cell    = out_last_q;

endmodule

### src/month_calendar_grid_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// month_calendar_grid_generator: Gregorian 6x7 month grid
// Turns a selected date into the 42 cells of its month view, Sunday first.
// ----------------------------------------------------------------------------
// Pulse start while busy is low with a selected date on sel_year, sel_month
// and sel_day. The block answers with 42 cell words in row-major order, one
// per clock, each shown for exactly one cycle with cell_valid high; there is
// no way to hold them off, so the receiver must take every word as it comes.
// The first cell word follows the setup steps and the last one carries
// last_cell. A request holds busy high through all of its steps, so a new
// request is taken only once the last one is through: six setup steps that
// find the weekday of the first of the month (two of them through the shared
// reciprocal multiplier), then 42 steps of the date counter.
// Out of range years and months are clamped (year to 1..9999, month to
// 1..12); sel_day is compared as given. The today registers are written on
// the cfg port at any time (cfg_ready is always high), index 0 year, 1 month,
// 2 day; other indexes are ignored. Write them only while busy is low.
// ----------------------------------------------------------------------------
module month_calendar_grid_generator
	import mcg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [YearW-1:0]  sel_year,
	input  logic [MonthW-1:0] sel_month,
	input  logic [DayW-1:0]   sel_day,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [YearW-1:0]  cfg_data,
	output logic              cell_valid,
	output logic [YearW-1:0]  cell_year,
	output logic [MonthW-1:0] cell_month,
	output logic [DayW-1:0]   cell_day,
	output logic [PosW-1:0]   cell_row,
	output logic [PosW-1:0]   cell_column,
	output logic              is_today,
	output logic              in_sel_month,
	output logic              is_selected,
	output logic              last_cell
);

	// Register map of the cfg port
	localparam logic [1:0] CFG_TODAY_YEAR  = 2'd0;
	localparam logic [1:0] CFG_TODAY_MONTH = 2'd1;
	localparam logic [1:0] CFG_TODAY_DAY   = 2'd2;

	logic [YearW-1:0]  today_year_q;
	logic [MonthW-1:0] today_month_q;
	logic [DayW-1:0]   today_day_q;

	dp_op_t     op;
	dp_status_t status;
	logic       busy_w;

	assign cfg_ready = 1'b1;

	// Today registers: take a word on every cfg handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			today_year_q  <= 14'd2000;
			today_month_q <= 4'd1;
			today_day_q   <= 5'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TODAY_YEAR:  today_year_q  <= cfg_data;
				CFG_TODAY_MONTH: today_month_q <= cfg_data[MonthW-1:0];
				CFG_TODAY_DAY:   today_day_q   <= cfg_data[DayW-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer: setup steps, then one cell per cycle
	mcg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.op     (op),
		.busy   (busy_w)
	);

	// Weekday arithmetic, date counter and flag compare
	mcg_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.status       (status),
		.sel_year     (sel_year),
		.sel_month    (sel_month),
		.sel_day      (sel_day),
		.today_year   (today_year_q),
		.today_month  (today_month_q),
		.today_day    (today_day_q),
		.cell_valid   (cell_valid),
		.cell_year    (cell_year),
		.cell_month   (cell_month),
		.cell_day     (cell_day),
		.cell_row     (cell_row),
		.cell_column  (cell_column),
		.is_today     (is_today),
		.in_sel_month (in_sel_month),
		.is_selected  (is_selected),
		.last_cell    (last_cell)
	);

	assign busy = busy_w;

endmodule

### test/tb_month_calendar_grid_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_month_calendar_grid_generator: self-checking bench for the month grid
// Drives selected dates and today settings into the grid generator and checks
// every one of the 42 cell words per request against an in-bench calendar.
// ----------------------------------------------------------------------------

import mcg_pkg::*;

typedef enum logic [1:0] {
	REG_TODAY_YEAR,
	REG_TODAY_MONTH,
	REG_TODAY_DAY,
	REG_SPARE
} reg_index_t;

typedef struct packed {
	logic [YearW-1:0]  year;
	logic [MonthW-1:0] month;
	logic [DayW-1:0]   day;
	logic [PosW-1:0]   row;
	logic [PosW-1:0]   column;
	logic              today;
	logic              insel;
	logic              sel;
	logic              last;
} cell_t;

class grid_scoreboard;
	cell_t             expected_cells[$];
	int unsigned       errors;
	logic [YearW-1:0]  today_year;
	logic [MonthW-1:0] today_month;
	logic [DayW-1:0]   today_day;

	function new();
		errors      = 0;
		today_year  = 14'd2000;
		today_month = 4'd1;
		today_day   = 5'd1;
	endfunction

	function void write_reg(reg_index_t idx, logic [YearW-1:0] data);
		case (idx)
			REG_TODAY_YEAR:  today_year  = data;
			REG_TODAY_MONTH: today_month = data[MonthW-1:0];
			REG_TODAY_DAY:   today_day   = data[DayW-1:0];
			default: ;
		endcase
	endfunction

	function int unsigned month_days(int unsigned m, bit leap);
		case (m)
			2:             return leap ? 29 : 28;
			4, 6, 9, 11:   return 30;
			default:       return 31;
		endcase
	endfunction

	// Build the 42 cells of the month view for one accepted date.
	function void note_date(logic [YearW-1:0] y, logic [MonthW-1:0] m, logic [DayW-1:0] d);
		int unsigned ey, em, doy, y1, wday, cy, cm, cd, i;
		bit          leap;
		cell_t       c;
		ey = y;
		em = m;
		if (ey < 1) ey = 1;
		if (ey > 9999) ey = 9999;
		if (em < 1) em = 1;
		if (em > 12) em = 12;
		leap = ((ey % 4 == 0) && (ey % 100 != 0)) || (ey % 400 == 0);
		doy = 1;
		for (i = 1; i < em; i++)
			doy += month_days(i, leap);
		y1 = ey - 1;
		wday = (y1 + y1 / 4 - y1 / 100 + y1 / 400 + doy) % 7;
		if (wday == 0)
			wday = 7;
		cy = ey;
		cm = em - 1;
		if (cm == 0) begin
			cm = 12;
			cy = ey - 1;
		end
		cd = month_days(cm, leap) - wday + 1;
		for (i = 0; i < 42; i++) begin
			c.year   = cy[YearW-1:0];
			c.month  = cm[MonthW-1:0];
			c.day    = cd[DayW-1:0];
			c.row    = PosW'(i / 7);
			c.column = PosW'(i % 7);
			c.today  = (cy == today_year) && (cm == today_month) && (cd == today_day);
			c.insel  = (cm == em);
			c.sel    = c.insel && (cy == ey) && (cd == d);
			c.last   = (i == 41);
			expected_cells.push_back(c);
			cd++;
			if (cd > month_days(cm, leap)) begin
				cd = 1;
				cm++;
				if (cm == 13) begin
					cm = 1;
					cy++;
				end
			end
		end
	endfunction

	function string show(cell_t c);
		return $sformatf("%0d-%0d-%0d row %0d col %0d today %b insel %b sel %b last %b",
			c.year, c.month, c.day, c.row, c.column, c.today, c.insel, c.sel, c.last);
	endfunction

	function void check_cell(cell_t got);
		cell_t want;
		if (expected_cells.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("%0t: unexpected cell word %s", $realtime, show(got));
			return;
		end
		want = expected_cells.pop_front();
		if (got !== want) begin
			errors++;
			if (errors <= 10)
				$display("%0t: cell mismatch\n  expected %s\n  actual   %s",
					$realtime, show(want), show(got));
		end
	endfunction

	function int unsigned pending();
		return expected_cells.size();
	endfunction
endclass

module tb_month_calendar_grid_generator;

	localparam int QUIET_LIMIT     = 1000;
	localparam int TAIL_CYCLES     = 60;
	localparam int ITEMS_PER_PHASE = 112;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [YearW-1:0]  sel_year;
	logic [MonthW-1:0] sel_month;
	logic [DayW-1:0]   sel_day;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [YearW-1:0]  cfg_data;
	logic              cell_valid;
	logic [YearW-1:0]  cell_year;
	logic [MonthW-1:0] cell_month;
	logic [DayW-1:0]   cell_day;
	logic [PosW-1:0]   cell_row;
	logic [PosW-1:0]   cell_column;
	logic              is_today;
	logic              in_sel_month;
	logic              is_selected;
	logic              last_cell;

	grid_scoreboard grid_sb = new();
	int             quiet_cycles;
	int             idle_pct;

	month_calendar_grid_generator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.sel_year     (sel_year),
		.sel_month    (sel_month),
		.sel_day      (sel_day),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cell_valid   (cell_valid),
		.cell_year    (cell_year),
		.cell_month   (cell_month),
		.cell_day     (cell_day),
		.cell_row     (cell_row),
		.cell_column  (cell_column),
		.is_today     (is_today),
		.in_sel_month (in_sel_month),
		.is_selected  (is_selected),
		.last_cell    (last_cell)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Take every cell word on the edge that ends its strobe cycle; the block
	// cannot be held off, so there is nothing to stall here.
	always @(posedge clk) begin
		if (arst_n && cell_valid)
			grid_sb.check_cell(cell_t'{cell_year, cell_month, cell_day, cell_row, cell_column,
				is_today, in_sel_month, is_selected, last_cell});
	end

	// Count cycles in which no word moves on any port.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((start && !busy) || cell_valid || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("%0t: no traffic for %0d cycles", $realtime, QUIET_LIMIT);
		$display("FAILURE");
		$finish;
	end

	// Write one today register; hold valid until the channel takes the word.
	task automatic write_reg(reg_index_t idx, logic [YearW-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		grid_sb.write_reg(idx, data);
	endtask

	// Load all three today registers, then drop valid. Month and day words carry
	// random upper bits, which the block must ignore.
	task automatic set_today(logic [YearW-1:0] y, logic [MonthW-1:0] m, logic [DayW-1:0] d);
		write_reg(REG_TODAY_YEAR, y);
		write_reg(REG_TODAY_MONTH, {10'($urandom), m});
		write_reg(REG_TODAY_DAY, {9'($urandom), d});
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Present one date. Before the request shows up, idle at random; once shown,
	// hold it until busy is low so it is accepted on the next rising edge.
	task automatic send_date(logic [YearW-1:0] y, logic [MonthW-1:0] m, logic [DayW-1:0] d);
		bit shown;
		bit done;
		shown = 1'b0;
		done  = 1'b0;
		while (!done) begin
			@(negedge clk);
			if (!shown && $urandom_range(99) < idle_pct) begin
				start = 1'b0;
			end else begin
				start     = 1'b1;
				sel_year  = y;
				sel_month = m;
				sel_day   = d;
				shown     = 1'b1;
				if (!busy) begin
					grid_sb.note_date(y, m, d);
					done = 1'b1;
				end
			end
		end
	endtask

	// Drop start and wait until every cell has come back and the block is idle.
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (grid_sb.pending() != 0 || busy)
			@(negedge clk);
	endtask

	// Pick one random date: mostly plain dates, some near the today setting so
	// the today flag fires, some century and range edges, some raw noise.
	task automatic send_random_date();
		int          r;
		int          m;
		logic [YearW-1:0] y;
		r = $urandom_range(99);
		if (r < 10) begin
			send_date(14'($urandom), 4'($urandom), 5'($urandom));
		end else if (r < 40) begin
			m = int'(grid_sb.today_month) + $urandom_range(2) - 1;
			send_date(grid_sb.today_year, 4'(m), 5'($urandom_range(1, 31)));
		end else if (r < 50) begin
			case ($urandom_range(5))
				0:       y = 14'd1;
				1:       y = 14'd9999;
				2:       y = 14'd1900;
				3:       y = 14'd2000;
				4:       y = 14'd2100;
				default: y = 14'd400;
			endcase
			send_date(y, 4'($urandom_range(1, 12)), 5'($urandom_range(1, 31)));
		end else begin
			send_date(14'($urandom_range(1, 9999)), 4'($urandom_range(1, 12)),
				5'($urandom_range(1, 31)));
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		sel_year  = '0;
		sel_month = '0;
		sel_day   = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_TODAY_YEAR;
		cfg_data  = '0;
		idle_pct  = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, first with the reset today date of 2000-01-01.
		send_date(14'd2000, 4'd1, 5'd1);
		send_date(14'd2000, 4'd2, 5'd29);    // leap February
		send_date(14'd1900, 4'd2, 5'd29);    // century, not leap: day absent
		send_date(14'd2023, 4'd1, 5'd15);    // first on a Sunday: full lead week
		send_date(14'd2015, 4'd2, 5'd28);    // Sunday start, 28-day February
		send_date(14'd2024, 4'd3, 5'd31);
		send_date(14'd2023, 4'd4, 5'd31);    // day the month lacks
		send_date(14'd0, 4'd5, 5'd10);       // year below range
		send_date(14'd16383, 4'd6, 5'd0);    // year above range, day zero
		send_date(14'd10000, 4'd7, 5'd20);
		send_date(14'd1, 4'd0, 5'd1);        // month zero, grid reaches year 0
		send_date(14'd9999, 4'd15, 5'd31);   // month above range, grid reaches 10000
		send_date(14'd9999, 4'd13, 5'd25);
		send_date(14'd1, 4'd1, 5'd31);
		send_date(14'd2100, 4'd12, 5'd31);
		send_date(14'd400, 4'd2, 5'd29);     // divisible by 400: leap
		send_date(14'd8191, 4'd8, 5'd8);
		drain();

		// Today in year 0, reached only by the lead-in of January of year 1.
		set_today(14'd0, 4'd12, 5'd31);
		send_date(14'd1, 4'd1, 5'd1);
		drain();

		// Today in year 10000, reached by the tail of December 9999.
		set_today(14'd10000, 4'd1, 5'd1);
		send_date(14'd9999, 4'd12, 5'd1);
		drain();

		// Register extremes, plus a write to the unused index that must be ignored.
		write_reg(REG_SPARE, 14'($urandom));
		set_today(14'd16383, 4'd15, 5'd31);
		send_date(14'd5000, 4'd6, 5'd15);
		drain();

		set_today(14'd2000, 4'd2, 5'd29);
		send_date(14'd2000, 4'd2, 5'd10);
		drain();

		// Random phases. The receiver cannot stall, so its phase runs the sender
		// flat out; the combined phase keeps the sender's share of idling.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0:       idle_pct = 0;
				1:       idle_pct = 75;
				2:       idle_pct = 0;
				default: idle_pct = 13;
			endcase
			if (phase == 1)
				set_today(14'($urandom), 4'($urandom), 5'($urandom));
			else
				set_today(14'($urandom_range(1, 9999)), 4'($urandom_range(1, 12)),
					5'($urandom_range(1, 31)));
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_random_date();
			drain();
		end

		// Let any stray words show up before the verdict.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (grid_sb.errors == 0 && grid_sb.pending() == 0) begin
			$display("SUCCESS");
		end else begin
			if (grid_sb.pending() != 0)
				$display("%0d expected cells never arrived", grid_sb.pending());
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### files.f
src/mcg_pkg.sv
src/mcg_ctrl.sv
src/mcg_dpath.sv
src/month_calendar_grid_generator.sv
test/tb_month_calendar_grid_generator.sv
